@@ sv/paged_frame_allocator_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the paged frame allocator checker
// Concurrent assertion shorthands, with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef PAGED_FRAME_ALLOCATOR_CORE_MACROS_SVH
`define PAGED_FRAME_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, dropped while reset is low.
`define PFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, dropped while reset is low.
`define PFA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define PFA_ASSERT_RST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/pfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Paged frame allocator package
// Table sizes, result status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int NUM_FRAMES = 32;
    localparam int IDX_W      = $clog2(NUM_FRAMES);
    localparam int CNT_W      = 6;
    localparam int PID_W      = 8;
    localparam int MEM_W      = 16;
    localparam int PS_W       = 13;
    localparam int FIU_W      = 6;
    localparam int CAP_W      = 18;

    localparam logic [PS_W-1:0]  PAGE_SIZE_RST     = PS_W'(100);
    localparam logic [FIU_W-1:0] FRAMES_IN_USE_RST = FIU_W'(20);

    localparam logic [1:0] ST_GRANT  = 2'd0;
    localparam logic [1:0] ST_REFUSE = 2'd1;
    localparam logic [1:0] ST_FREED  = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    localparam logic REG_PAGE_SIZE     = 1'b0;
    localparam logic REG_FRAMES_IN_USE = 1'b1;

    typedef struct packed {
        logic       load;
        logic       clr;
        logic       free_step;
        logic       cnt_step;
        logic       grant_step;
        logic       emit;
        logic [1:0] emit_code;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic mem_zero;
        logic idx_last;
        logic fits;
        logic hit;
        logic grant_last;
        logic out_free;
    } t_stat;

endpackage

@@ sv/pfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Paged frame allocator controller
// Sequences dispatch, table scans, grants and single-result emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pfa_pkg::t_stat i_stat,
    output pfa_pkg::t_cmd  o_cmd
);
    import pfa_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE        = 9'b000000001,
        S_DISPATCH    = 9'b000000010,
        S_FREE_SCAN   = 9'b000000100,
        S_CNT_SCAN    = 9'b000001000,
        S_CHECK       = 9'b000010000,
        S_GRANT       = 9'b000100000,
        S_EMIT_FREED  = 9'b001000000,
        S_EMIT_EMPTY  = 9'b010000000,
        S_EMIT_REFUSE = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.clr = 1'b1;
                if (i_stat.mode) begin
                    n_state = S_FREE_SCAN;
                end else if (i_stat.mem_zero) begin
                    n_state = S_EMIT_EMPTY;
                end else begin
                    n_state = S_CNT_SCAN;
                end
            end
            S_FREE_SCAN: begin
                o_cmd.free_step = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_EMIT_FREED;
                end
            end
            S_CNT_SCAN: begin
                o_cmd.cnt_step = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.clr = 1'b1;
                n_state   = i_stat.fits ? S_GRANT : S_EMIT_REFUSE;
            end
            S_GRANT: begin
                // a free frame waits for the output slot, other frames are skipped
                if (!i_stat.hit || i_stat.out_free) begin
                    o_cmd.grant_step = 1'b1;
                    if (i_stat.hit && i_stat.grant_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT_FREED: begin
                o_cmd.emit_code = ST_FREED;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_EMIT_EMPTY: begin
                o_cmd.emit_code = ST_EMPTY;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_EMIT_REFUSE: begin
                o_cmd.emit_code = ST_REFUSE;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/pfa_datapath.sv @@
// ----------------------------------------------------------------------------
// Paged frame allocator datapath
// Frame owner table, scan index, capacity accumulators and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfa_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pfa_pkg::t_cmd               i_cmd,
    output pfa_pkg::t_stat              o_stat,
    input  logic                        i_mode,
    input  logic [pfa_pkg::PID_W-1:0]   i_pid,
    input  logic [pfa_pkg::MEM_W-1:0]   i_mem,
    input  logic [pfa_pkg::PS_W-1:0]    i_page_size,
    input  logic [pfa_pkg::FIU_W-1:0]   i_frames_in_use,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_status,
    output logic [4:0]                  o_frame,
    output logic [5:0]                  o_page,
    output logic [pfa_pkg::CNT_W-1:0]   o_freed,
    output logic                        o_last
);
    import pfa_pkg::*;

    logic [PID_W-1:0] r_owner [NUM_FRAMES];
    logic             r_mode;
    logic [PID_W-1:0] r_pid;
    logic [MEM_W-1:0] r_mem;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_cnt;
    logic [CAP_W-1:0] r_cap;
    logic [CAP_W-1:0] r_acc;
    logic [5:0]       r_page;
    logic             r_out_valid;
    logic             n_out_valid;

    logic [PS_W-1:0]  w_ps;
    logic [FIU_W:0]   w_usable;
    logic             w_in_range;
    logic             w_free_frame;
    logic             w_own_frame;
    logic [CAP_W-1:0] w_acc_next;
    logic             w_grant;
    logic             w_out_free;

    assign w_ps         = (i_page_size == '0) ? PS_W'(1) : i_page_size;
    assign w_usable     = ({1'b0, i_frames_in_use} > (FIU_W+1)'(NUM_FRAMES))
                        ? (FIU_W+1)'(NUM_FRAMES) : {1'b0, i_frames_in_use};
    assign w_in_range   = ((FIU_W+1)'(r_idx) < w_usable);
    assign w_free_frame = w_in_range && (r_owner[r_idx] == '0);
    assign w_own_frame  = (r_pid != '0) && (r_owner[r_idx] == r_pid);
    assign w_acc_next   = r_acc + CAP_W'(w_ps);
    assign w_grant      = i_cmd.grant_step && w_free_frame;
    assign w_out_free   = !r_out_valid || i_ready;

    assign o_stat.mode       = r_mode;
    assign o_stat.mem_zero   = (r_mem == '0);
    assign o_stat.idx_last   = (r_idx == IDX_W'(NUM_FRAMES - 1));
    assign o_stat.fits       = (r_pid != '0) && (CAP_W'(r_mem) <= r_cap);
    assign o_stat.hit        = w_free_frame;
    assign o_stat.grant_last = (w_acc_next >= CAP_W'(r_mem));
    assign o_stat.out_free   = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_FRAMES; k++) begin
                r_owner[k] <= '0;
            end
        end else if (i_cmd.free_step && w_own_frame) begin
            r_owner[r_idx] <= '0;
        end else if (w_grant) begin
            r_owner[r_idx] <= r_pid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_pid  <= i_pid;
            r_mem  <= i_mem;
        end
        if (i_cmd.clr) begin
            r_idx  <= '0;
            r_cnt  <= '0;
            r_cap  <= '0;
            r_acc  <= '0;
            r_page <= '0;
        end else begin
            if (i_cmd.free_step || i_cmd.cnt_step || i_cmd.grant_step) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.free_step && w_own_frame) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.cnt_step && w_free_frame) begin
                r_cap <= r_cap + CAP_W'(w_ps);
            end
            if (w_grant) begin
                r_acc  <= w_acc_next;
                r_page <= r_page + 6'd1;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.emit || w_grant) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_grant) begin
            o_status <= ST_GRANT;
            o_frame  <= 5'(r_idx);
            o_page   <= r_page + 6'd1;
            o_freed  <= '0;
            o_last   <= o_stat.grant_last;
        end else if (i_cmd.emit) begin
            o_status <= i_cmd.emit_code;
            o_frame  <= '0;
            o_page   <= '0;
            o_freed  <= (i_cmd.emit_code == ST_FREED) ? r_cnt : '0;
            o_last   <= 1'b1;
        end
    end

    assign o_valid = r_out_valid;

endmodule

@@ sv/paged_frame_allocator_core.sv @@
// ----------------------------------------------------------------------------
// Paged frame allocator core
// Owner table for page frames with first-free allocation and bulk release.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream: s_tuser carries the mode (allocate or
//   free), s_tdata the process id and the memory size. Results leave on the
//   m_ stream, one item per granted page, or one item for a refusal, an empty
//   request or a free summary; m_tlast marks the final item of a request.
//   The APB port holds page_size (0x0) and frames_in_use (0x4); write when idle.
//   Timing: one request at a time. An empty request goes from dispatch
//   straight to its result. Free: the result follows a scan of the whole
//   32-entry table. Allocate: a free-frame count over the table and a
//   decision state come before a refusal or the earliest grant; the grant
//   scan walks one frame per cycle unless a stall holds it.
//   s_tready rises at the edge that writes the final item of a request.
//   Reset: every frame is free, page_size is 100 and frames_in_use is 20.
//   Stall: a result waits in the output register; the grant scan holds on
//   a free frame until the slot is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module paged_frame_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] process_id, [23:8] mem_request
    input  logic        s_tuser,   // [0] mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [4:0] frame_index, [10:5] page_number,
                                   // [16:11] freed_count, [23:17] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);
    import pfa_pkg::*;

    logic [PS_W-1:0]  r_page_size;
    logic [FIU_W-1:0] r_frames_in_use;
    logic             w_wr;
    t_cmd             w_cmd;
    t_stat            w_stat;
    logic [4:0]       w_frame;
    logic [5:0]       w_page;
    logic [CNT_W-1:0] w_freed;

    // APB: zero wait states, write on the access phase
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size     <= PAGE_SIZE_RST;
            r_frames_in_use <= FRAMES_IN_USE_RST;
        end else if (w_wr) begin
            if (paddr[2] == REG_PAGE_SIZE) begin
                r_page_size <= pwdata[PS_W-1:0];
            end else begin
                r_frames_in_use <= pwdata[FIU_W-1:0];
            end
        end
    end

    // read back the register picked by the word address
    always_comb begin
        case (paddr[2])
            REG_PAGE_SIZE:     prdata = {{(32-PS_W){1'b0}}, r_page_size};
            REG_FRAMES_IN_USE: prdata = {{(32-FIU_W){1'b0}}, r_frames_in_use};
            default:           prdata = '0;
        endcase
    end

    pfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pfa_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_mode          (s_tuser),
        .i_pid           (s_tdata[7:0]),
        .i_mem           (s_tdata[23:8]),
        .i_page_size     (r_page_size),
        .i_frames_in_use (r_frames_in_use),
        .o_valid         (m_tvalid),
        .i_ready         (m_tready),
        .o_status        (m_tuser),
        .o_frame         (w_frame),
        .o_page          (w_page),
        .o_freed         (w_freed),
        .o_last          (m_tlast)
    );

    // pack the result fields, lowest field first
    assign m_tdata = {7'd0, w_freed, w_page, w_frame};

endmodule

@@ sv/pfa_checker.sv @@
// ----------------------------------------------------------------------------
// Paged frame allocator port checker
// Watches the result stream and request readiness of the core over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "paged_frame_allocator_core_macros.svh"

module pfa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import pfa_pkg::*;

    // no result survives reset
    `PFA_ASSERT_RST(a_rst_clears_out, i_clk, !i_rst_n, !m_tvalid, "result valid after reset")

    // hold a stalled result
    `PFA_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // single results are final and carry no frame or page
    `PFA_ASSERT_IMP(a_single_final, i_clk, i_rst_n, m_tvalid && (m_tuser != ST_GRANT), m_tlast && (m_tdata[10:0] == 11'd0), "single result malformed")

    // a grant run still open keeps the request side closed
    `PFA_ASSERT_IMP(a_grant_busy, i_clk, i_rst_n, m_tvalid && (m_tuser == ST_GRANT) && !m_tlast, !s_tready, "request taken during grant run")

endmodule

bind paged_frame_allocator_core pfa_checker u_pfa_checker (.*);

@@ bench/pfa_bench_pkg.sv @@
// ----------------------------------------------------------------------------
// Paged frame allocator bench package
// Request modes and register addresses shared by the checker and the bench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfa_bench_pkg;

    // request mode, carried on s_tuser
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // byte addresses of the two registers on the APB port
    localparam logic [2:0] ADDR_PAGE_SIZE     = {pfa_pkg::REG_PAGE_SIZE, 2'b00};
    localparam logic [2:0] ADDR_FRAMES_IN_USE = {pfa_pkg::REG_FRAMES_IN_USE, 2'b00};

endpackage

@@ bench/frame_alloc_checker.sv @@
// ----------------------------------------------------------------------------
// Paged frame allocator checker
// Follows register writes and requests, predicts the grant, refusal, empty
// and release items of each request, and compares every result item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_alloc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // [7:0] process_id, [23:8] mem_request
    input  logic        i_s_tuser,   // [0] mode
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [4:0] frame_index, [10:5] page_number,
                                     // [16:11] freed_count, [23:17] zero
    input  logic [1:0]  i_m_tuser,   // [1:0] status
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_requests,
    output int          o_results,
    output int          o_grants,
    output int          o_refusals
);
    import pfa_pkg::*;
    import pfa_bench_pkg::*;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] frame_index;
        logic [5:0] page_number;
        logic [5:0] freed_count;
        logic       last;
    } t_frame_result;

    t_frame_result    frame_results_q[$];
    logic [PID_W-1:0] owner_tbl [NUM_FRAMES];
    logic [PS_W-1:0]  page_size_q;
    logic [FIU_W-1:0] frames_in_use_q;
    int               fail_count = 0;
    int               requests   = 0;
    int               results    = 0;
    int               grants     = 0;
    int               refusals   = 0;

    assign o_fail_count = fail_count;
    assign o_requests   = requests;
    assign o_results    = results;
    assign o_grants     = grants;
    assign o_refusals   = refusals;

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("%0t checker: %s", $time, msg);
    endtask

    task automatic queue_result(input logic [1:0] status, input int unsigned frame,
                                input int unsigned page, input int unsigned freed,
                                input logic last);
        t_frame_result r;
        r.status      = status;
        r.frame_index = 5'(frame);
        r.page_number = 6'(page);
        r.freed_count = 6'(freed);
        r.last        = last;
        frame_results_q = {frame_results_q, r};
    endtask

    // Work out the items of one request and update the owner table.
    task automatic predict_frames(input logic mode, input logic [PID_W-1:0] pid,
                                  input logic [MEM_W-1:0] mem);
        int unsigned unit;
        int unsigned pages;
        int unsigned usable;
        int unsigned open_cnt;
        int unsigned page;
        int unsigned released;
        released = 0;
        open_cnt = 0;
        page     = 0;
        if (mode == MODE_FREE) begin
            // release everywhere, including frames above the usable count
            if (pid != '0) begin
                for (int f = 0; f < NUM_FRAMES; f++) begin
                    if (owner_tbl[f] == pid) begin
                        owner_tbl[f] = '0;
                        released++;
                    end
                end
            end
            if (released > 63) released = 63;
            queue_result(ST_FREED, 0, 0, released, 1'b1);
        end else if (mem == '0) begin
            queue_result(ST_EMPTY, 0, 0, 0, 1'b1);
        end else begin
            unit   = (page_size_q == '0) ? 1 : int'(page_size_q);
            pages  = (int'(mem) + unit - 1) / unit;
            usable = frames_in_use_q;
            if (usable > NUM_FRAMES) usable = NUM_FRAMES;
            if (usable > 32) usable = 32;
            for (int f = 0; f < usable; f++) begin
                if (owner_tbl[f] == '0) open_cnt++;
            end
            if (pid == '0 || pages > open_cnt) begin
                queue_result(ST_REFUSE, 0, 0, 0, 1'b1);
            end else begin
                for (int f = 0; f < usable && page < pages; f++) begin
                    if (owner_tbl[f] == '0) begin
                        owner_tbl[f] = pid;
                        page++;
                        queue_result(ST_GRANT, f, page, 0, page == pages);
                    end
                end
            end
        end
    endtask

    task automatic check_frame_result(input logic [23:0] data, input logic [1:0] status,
                                      input logic last);
        t_frame_result got;
        t_frame_result want;
        got.status      = status;
        got.frame_index = data[4:0];
        got.page_number = data[10:5];
        got.freed_count = data[16:11];
        got.last        = last;
        results++;
        if (status == ST_GRANT) grants++;
        if (status == ST_REFUSE) refusals++;
        if (frame_results_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item st %0d frame %0d page %0d freed %0d last %0d",
                                      got.status, got.frame_index, got.page_number,
                                      got.freed_count, got.last));
        end else begin
            want = frame_results_q[0];
            frame_results_q.delete(0);
            if (got != want || data[23:17] != '0) begin
                report_mismatch($sformatf(
                    "want st %0d frame %0d page %0d freed %0d last %0d, got %0d %0d %0d %0d %0d pad %h",
                    want.status, want.frame_index, want.page_number, want.freed_count, want.last,
                    got.status, got.frame_index, got.page_number, got.freed_count, got.last,
                    data[23:17]));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < NUM_FRAMES; f++) owner_tbl[f] = '0;
            page_size_q     = PAGE_SIZE_RST;
            frames_in_use_q = FRAMES_IN_USE_RST;
            frame_results_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr)
                    ADDR_PAGE_SIZE:     page_size_q     = i_pwdata[PS_W-1:0];
                    ADDR_FRAMES_IN_USE: frames_in_use_q = i_pwdata[FIU_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                check_frame_result(i_m_tdata, i_m_tuser, i_m_tlast);
            end
            if (i_s_tvalid && i_s_tready) begin
                requests++;
                predict_frames(i_s_tuser, i_s_tdata[7:0], i_s_tdata[23:8]);
            end
        end
        o_pending <= frame_results_q.size();
    end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Paged frame allocator testbench
// Drives allocate and free requests through the allocator core under several
// page size and frame count settings, with random gaps on both streams; the
// checker beside the core predicts and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import pfa_pkg::*;
    import pfa_bench_pkg::*;

    // quiet cycles allowed before the run is called hung; the longest honest
    // gap is a full allocate request followed by a long receiver stall
    localparam int QUIET_LIMIT  = 2000;
    // cycles to hold after the last result, one full request and a margin
    localparam int TAIL_CYCLES  = 70;
    // hold-off before a register write, after the last result of a request
    localparam int SETTLE_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // [7:0] process_id, [23:8] mem_request
    logic        s_tuser;    // [0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [4:0] frame_index, [10:5] page_number,
                             // [16:11] freed_count, [23:17] zero
    logic [1:0]  m_tuser;    // [1:0] status
    logic        m_tlast;

    int          fail_count;
    int          pending;
    int          requests;
    int          results;
    int          grants;
    int          refusals;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          quiet_cycles = 0;
    int          settings = 0;
    int unsigned cur_page_size = 100;
    logic [7:0]  live_pids[$];

    paged_frame_allocator_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    frame_alloc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_requests   (requests),
        .o_results    (results),
        .o_grants     (grants),
        .o_refusals   (refusals)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: drop tready at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog: count cycles in which no item moves on either stream and no
    // register access completes; give up when the count reaches the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Offer one request and hold it until the core takes it. Idle first at
    // the phase's rate, scrambling the data so that only valid items count.
    task automatic send_request(input logic mode, input logic [7:0] pid,
                                input logic [15:0] mem);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 24'($urandom);
            s_tuser  <= 1'($urandom);
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {mem, pid};
        s_tuser  <= mode;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Drop the request stream and hold until every predicted item is back,
    // then wait out the settle hold-off before touching registers.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle, then an idle cycle with the bus released
    // so that back-to-back writes never assign psel twice in one step.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_core(input logic [12:0] page_size, input logic [5:0] frames);
        settle();
        apb_write(ADDR_PAGE_SIZE, 32'(page_size));
        apb_write(ADDR_FRAMES_IN_USE, 32'(frames));
        cur_page_size = page_size;
        settings++;
    endtask

    // Pick a setting, leaning on the extremes: page size zero stands for one,
    // and frame counts above the table are clamped by the core.
    task automatic pick_setting();
        logic [12:0] ps;
        logic [5:0]  frames;
        case ($urandom_range(0, 7))
            0:       ps = 13'd0;
            1:       ps = 13'd1;
            2:       ps = 13'd8191;
            3:       ps = 13'd4096;
            4:       ps = 13'd200;
            5:       ps = 13'd400;
            default: ps = 13'($urandom_range(1, 600));
        endcase
        case ($urandom_range(0, 7))
            0:       frames = 6'd0;
            1:       frames = 6'd1;
            2:       frames = 6'd63;
            3:       frames = 6'd32;
            default: frames = 6'($urandom_range(8, 32));
        endcase
        program_core(ps, frames);
    endtask

    // Memory size worth a given number of pages at the current page size.
    function automatic logic [15:0] size_for_pages(input int unsigned pages);
        int unsigned unit;
        int unsigned total;
        unit  = (cur_page_size == 0) ? 1 : cur_page_size;
        total = (pages - 1) * unit + $urandom_range(1, unit);
        if (total > 65535) total = 65535;
        return 16'(total);
    endfunction

    // Mostly well-formed traffic: allocate for a process, free it later;
    // the rest is noise such as process id zero, empty and oversized requests.
    task automatic random_request();
        int unsigned pick;
        int unsigned idx;
        logic [7:0]  pid;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            if (live_pids.size() > 0 && $urandom_range(0, 4) == 0) begin
                pid = live_pids[$urandom_range(0, live_pids.size() - 1)];
            end else begin
                pid = 8'($urandom_range(1, 255));
                live_pids = {live_pids, pid};
            end
            send_request(MODE_ALLOC, pid, size_for_pages($urandom_range(1, 6)));
        end else if (pick < 85) begin
            if (live_pids.size() == 0) begin
                pid = 8'($urandom_range(1, 255));
            end else begin
                idx = $urandom_range(0, live_pids.size() - 1);
                pid = live_pids[idx];
                live_pids.delete(idx);
            end
            send_request(MODE_FREE, pid, 16'($urandom));
        end else begin
            case ($urandom_range(0, 4))
                0:       send_request(MODE_ALLOC, 8'd0, 16'($urandom));
                1:       send_request(MODE_FREE, 8'd0, 16'($urandom));
                2:       send_request(MODE_ALLOC, 8'($urandom_range(1, 255)), 16'd0);
                3:       send_request(MODE_ALLOC, 8'($urandom_range(1, 255)), 16'($urandom));
                default: send_request(MODE_FREE, 8'($urandom_range(1, 255)), 16'($urandom));
            endcase
        end
    endtask

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) pick_setting();
            random_request();
        end
    endtask

    task automatic directed_requests();
        // reset setting: page size 100, 20 frames
        send_request(MODE_ALLOC, 8'd1, 16'd1);         // one page, frame 0
        send_request(MODE_ALLOC, 8'd2, 16'd100);       // exactly one page
        send_request(MODE_ALLOC, 8'd3, 16'd101);       // rounds up to two pages
        send_request(MODE_ALLOC, 8'd4, 16'd0);         // empty request
        send_request(MODE_ALLOC, 8'd0, 16'd50);        // id zero refused
        send_request(MODE_ALLOC, 8'd255, 16'd2000);    // too few free frames
        send_request(MODE_ALLOC, 8'd1, 16'd250);       // repeat owner, pages from 1
        send_request(MODE_FREE, 8'd2, 16'hFFFF);       // leaves a hole at frame 1
        send_request(MODE_ALLOC, 8'd5, 16'd300);       // fills the hole first
        send_request(MODE_FREE, 8'd0, 16'd0);          // id zero releases nothing
        send_request(MODE_FREE, 8'd77, 16'd0);         // owner of nothing
        send_request(MODE_ALLOC, 8'd255, 16'hFFFF);    // largest size
        send_request(MODE_ALLOC, 8'd6, 16'd1100);      // takes every free frame
        send_request(MODE_ALLOC, 8'd7, 16'd1);         // table full
        send_request(MODE_FREE, 8'd1, 16'd0);
        send_request(MODE_FREE, 8'd3, 16'd0);
        send_request(MODE_FREE, 8'd5, 16'd0);
        send_request(MODE_FREE, 8'd6, 16'd0);
        // page size zero acts as one; frame count clamps to the whole table
        program_core(13'd0, 6'd63);
        send_request(MODE_ALLOC, 8'h80, 16'd32);       // most items of one request
        // shrink the usable range; release still reaches every owned frame
        program_core(13'd0, 6'd4);
        send_request(MODE_FREE, 8'h80, 16'd0);
        send_request(MODE_ALLOC, 8'hAA, 16'd5);
        send_request(MODE_ALLOC, 8'h55, 16'd4);
        program_core(13'd8191, 6'd0);
        send_request(MODE_ALLOC, 8'd9, 16'd1);         // no usable frame at all
        program_core(13'd8191, 6'd32);
        send_request(MODE_ALLOC, 8'd9, 16'hFFFF);      // nine of the largest pages
        send_request(MODE_FREE, 8'h55, 16'd0);
        send_request(MODE_FREE, 8'd9, 16'd0);
    endtask

    initial begin
        i_rst_n  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= MODE_ALLOC;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender mostly busy, receiver stalling often
        tx_idle_pct = 13;
        rx_idle_pct = 56;
        directed_requests();
        random_phase(150);

        // swap the pressure: sparse requests, eager receiver
        tx_idle_pct = 56;
        rx_idle_pct = 13;
        random_phase(150);

        // both sides flat out
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(144);

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("tb: %0d requests over %0d register settings, %0d result items checked",
                 requests, settings, results);
        $display("tb: %0d frames granted, %0d refusals, %0d mismatches",
                 grants, refusals, fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/pfa_pkg.sv
sv/pfa_ctrl.sv
sv/pfa_datapath.sv
sv/paged_frame_allocator_core.sv
sv/pfa_checker.sv
bench/pfa_bench_pkg.sv
bench/frame_alloc_checker.sv
bench/tb.sv
